// File: src/vbad_pkg.sv
package vbad_pkg;

  // geometry limits
  localparam int MAX_AXIS      = 512;
  localparam int PLANE_ENTRIES = 65536;
  localparam int MAX_FACTOR    = 8;

  // field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int SIZE_W     = 10;
  localparam int AXIS_W     = $clog2(MAX_AXIS);
  localparam int FACTOR_W   = 4;
  localparam int FILL_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BINARIZE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE = 3'd5;

  // axis division by reciprocal: q = (v * m) >> RCP_SH
  localparam int REM_W    = $clog2(MAX_FACTOR);
  localparam int RCP_SH   = 16;
  localparam int RCP_W    = 17;
  localparam int AXPROD_W = SIZE_W + RCP_W;
  localparam int IDX_W    = 2 * SIZE_W;
  localparam int ADDR_W   = $clog2(PLANE_ENTRIES);

  // cube average by reciprocal: q = (|sum| * m) >> RCP3_SH
  localparam int SUM_W   = 25;
  localparam int RCP3_SH = 34;
  localparam int RCP3_W  = 32;
  localparam int PROD_W  = SUM_W + RCP3_W;
  localparam int QUO_W   = PROD_W - RCP3_SH;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int PTR_W   = $clog2(Q_DEPTH);
  localparam int LVL_W   = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [SIZE_W-1:0]   size_x;
    logic [SIZE_W-1:0]   size_y;
    logic [SIZE_W-1:0]   size_z;
    logic [FACTOR_W-1:0] factor;
    logic                binarize;
    logic [FILL_W-1:0]   fill_value;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [ADDR_W-1:0]          addr;
    logic                       addr_ok;
    logic                       first;
    logic                       emit;
    logic                       last;
    logic                       pass;
  } q_ent_t;

  typedef struct packed {
    logic   valid;
    q_ent_t ent;
  } q_push_t;

  typedef struct packed {
    logic             empty;
    logic [LVL_W-1:0] level;
  } q_stat_t;

  // size 0 acts as 1, sizes above the limit act as the limit
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    begin
      r = v;
      if (v == '0) r = SIZE_W'(1);
      else if (v > SIZE_W'(MAX_AXIS)) r = SIZE_W'(MAX_AXIS);
      return r;
    end
  endfunction

  function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] v);
    logic [FACTOR_W-1:0] r;
    begin
      r = v;
      if (v == '0) r = FACTOR_W'(1);
      else if (v > FACTOR_W'(MAX_FACTOR)) r = FACTOR_W'(MAX_FACTOR);
      return r;
    end
  endfunction

  // ceil(2^16 / f), exact floor division for values below 1024
  function automatic logic [RCP_W-1:0] recip_axis(input logic [FACTOR_W-1:0] f);
    logic [RCP_W-1:0] m;
    begin
      case (f)
        4'd1:    m = 17'd65536;
        4'd2:    m = 17'd32768;
        4'd3:    m = 17'd21846;
        4'd4:    m = 17'd16384;
        4'd5:    m = 17'd13108;
        4'd6:    m = 17'd10923;
        4'd7:    m = 17'd9363;
        4'd8:    m = 17'd8192;
        default: m = 17'd65536;
      endcase
      return m;
    end
  endfunction

  // ceil(2^34 / f^3), exact floor division for magnitudes up to 2^24
  function automatic logic [RCP3_W-1:0] recip_cube(input logic [FACTOR_W-1:0] f);
    logic [RCP3_W-1:0] m;
    begin
      case (f)
        4'd2:    m = 32'd2147483648;
        4'd3:    m = 32'd636291452;
        4'd4:    m = 32'd268435456;
        4'd5:    m = 32'd137438954;
        4'd6:    m = 32'd79536432;
        4'd7:    m = 32'd50087083;
        4'd8:    m = 32'd33554432;
        default: m = '0;
      endcase
      return m;
    end
  endfunction

endpackage

// File: src/vbad_if.sv
interface vbad_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vbad_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface vbad_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vbad_pkg::SAMPLE_W-1:0] average;
  logic                                last_of_volume;

  modport source (output valid, output average, output last_of_volume, input ready);
  modport sink   (input valid, input average, input last_of_volume, output ready);
endinterface

// File: src/volume_block_average_downsampler.sv
// channel   dir   handshake          payload
// in_ch     in    valid / ready      sample (s16)
// out_ch    out   valid / ready      average (s16), last_of_volume
// cfg_*     in    cfg_we             cfg_index (3), cfg_wdata (10)
//
// The front takes one item per cycle while the four-entry queue can hold every item
// in flight; an item passes the stage 1 and stage 2 registers before it is written
// into the queue. The back sets the rate and pops only from idle: an item that does
// not complete a cube goes through pop and a read-modify-write of the partial sum store,
// one that completes one goes through pop, update, multiply and output, and at factor 1
// an item goes from pop straight to output. Reset is synchronous and clears cursors,
// queue and sequencer; the partial sum store has no reset and needs no clearing pass.
// A stalled output holds its result; the back then stops and the queue fills.
module volume_block_average_downsampler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vbad_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vbad_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  vbad_in_if.sink                             in_ch,
  vbad_out_if.source                          out_ch
);

  vbad_pkg::cfg_t    cfg_r, cfg_nxt;
  vbad_pkg::q_push_t fe_push;
  vbad_pkg::q_ent_t  q_ent;
  vbad_pkg::q_stat_t q_stat;
  logic              bk_pop;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        vbad_pkg::CFG_SIZE_X:     cfg_nxt.size_x     = cfg_wdata;
        vbad_pkg::CFG_SIZE_Y:     cfg_nxt.size_y     = cfg_wdata;
        vbad_pkg::CFG_SIZE_Z:     cfg_nxt.size_z     = cfg_wdata;
        vbad_pkg::CFG_FACTOR:     cfg_nxt.factor     = cfg_wdata[vbad_pkg::FACTOR_W-1:0];
        vbad_pkg::CFG_BINARIZE:   cfg_nxt.binarize   = cfg_wdata[0];
        vbad_pkg::CFG_FILL_VALUE: cfg_nxt.fill_value = cfg_wdata[vbad_pkg::FILL_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_x     <= vbad_pkg::SIZE_W'(512);
      cfg_r.size_y     <= vbad_pkg::SIZE_W'(512);
      cfg_r.size_z     <= vbad_pkg::SIZE_W'(512);
      cfg_r.factor     <= vbad_pkg::FACTOR_W'(2);
      cfg_r.binarize   <= 1'b0;
      cfg_r.fill_value <= vbad_pkg::FILL_W'(255);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classify and index items
  vbad_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (fe_push)
  );

  // decoupling queue
  vbad_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .pop   (bk_pop),
    .ent   (q_ent),
    .stat  (q_stat)
  );

  // accumulate, average and emit
  vbad_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_ent  (q_ent),
    .q_stat (q_stat),
    .pop    (bk_pop),
    .out_ch (out_ch)
  );

  // credit scheme never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(fe_push.valid && (q_stat.level == vbad_pkg::LVL_W'(vbad_pkg::Q_DEPTH))))
    else $error("push into full queue");

  // back only pops a queue that holds an item
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    bk_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // fill level never exceeds depth
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= vbad_pkg::LVL_W'(vbad_pkg::Q_DEPTH))
    else $error("queue level out of range");

endmodule

// File: src/vbad_fifo.sv
module vbad_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  vbad_pkg::q_push_t push,
  input  logic              pop,
  output vbad_pkg::q_ent_t  ent,
  output vbad_pkg::q_stat_t stat
);

  vbad_pkg::q_ent_t                  q_mem_r [vbad_pkg::Q_DEPTH];
  logic [vbad_pkg::PTR_W-1:0]        wp_r, wp_nxt;
  logic [vbad_pkg::PTR_W-1:0]        rp_r, rp_nxt;
  logic [vbad_pkg::LVL_W-1:0]        level_r, level_nxt;

  // pointer and fill level update
  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    level_nxt = level_r;
    if (push.valid) wp_nxt = wp_r + 1'b1;
    if (pop) rp_nxt = rp_r + 1'b1;
    if (push.valid && !pop) level_nxt = level_r + 1'b1;
    else if (!push.valid && pop) level_nxt = level_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      level_r <= level_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) q_mem_r[wp_r] <= push.ent;
  end

  assign ent        = q_mem_r[rp_r];
  assign stat.empty = (level_r == '0);
  assign stat.level = level_r;

endmodule

// File: src/vbad_front.sv
module vbad_front (
  input  logic              clk,
  input  logic              rst_n,
  input  vbad_pkg::cfg_t    cfg,
  vbad_in_if.sink           in_ch,
  input  vbad_pkg::q_stat_t q_stat,
  output vbad_pkg::q_push_t push
);

  logic [vbad_pkg::SIZE_W-1:0]   sx, sy, sz;
  logic [vbad_pkg::FACTOR_W-1:0] f, fm1;
  logic [vbad_pkg::RCP_W-1:0]    rf;
  logic                          accept;
  logic [vbad_pkg::LVL_W:0]      busy;

  // raster cursor
  logic [vbad_pkg::AXIS_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [vbad_pkg::SIZE_W-1:0] x_inc, y_inc, z_inc;

  // cube counts per axis
  logic [vbad_pkg::SIZE_W-1:0]   ncx_r, ncx_nxt, ncy_r, ncy_nxt, ncz_r, ncz_nxt;
  logic [vbad_pkg::AXPROD_W-1:0] pnx, pny, pnz;

  // stage 1: accepted item
  logic                               st1_v_r;
  logic [vbad_pkg::AXIS_W-1:0]        x1_r, y1_r, z1_r;
  logic signed [vbad_pkg::SAMPLE_W-1:0] s1_r;
  logic [vbad_pkg::AXPROD_W-1:0]      px, py, pz;

  // stage 2: cube coordinates
  logic                               st2_v_r;
  logic [vbad_pkg::AXIS_W-1:0]        x2_r, y2_r, z2_r;
  logic [vbad_pkg::AXIS_W-1:0]        qx2_r, qy2_r, qz2_r;
  logic signed [vbad_pkg::SAMPLE_W-1:0] s2_r;

  logic [vbad_pkg::SIZE_W-1:0] mx, my, mz, dx, dy, dz;
  logic [vbad_pkg::REM_W-1:0]  rx, ry, rz, rlast;
  logic                        inbox, first, lastv, lastc;
  logic [vbad_pkg::IDX_W-1:0]  idx;

  // clamped configuration
  assign sx    = vbad_pkg::clamp_size(cfg.size_x);
  assign sy    = vbad_pkg::clamp_size(cfg.size_y);
  assign sz    = vbad_pkg::clamp_size(cfg.size_z);
  assign f     = vbad_pkg::clamp_factor(cfg.factor);
  assign fm1   = f - 1'b1;
  assign rlast = fm1[vbad_pkg::REM_W-1:0];
  assign rf    = vbad_pkg::recip_axis(f);

  // credit: accept only while the queue can hold every item in flight
  assign busy = {1'b0, q_stat.level} + (vbad_pkg::LVL_W+1)'(st1_v_r)
              + (vbad_pkg::LVL_W+1)'(st2_v_r);
  assign in_ch.ready = (busy < (vbad_pkg::LVL_W+1)'(vbad_pkg::Q_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  // cursor advance, x fastest
  always_comb begin
    x_inc = {1'b0, x_r} + 1'b1;
    y_inc = {1'b0, y_r} + 1'b1;
    z_inc = {1'b0, z_r} + 1'b1;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (accept) begin
      if (x_inc >= sx) begin
        x_nxt = '0;
        if (y_inc >= sy) begin
          y_nxt = '0;
          z_nxt = (z_inc >= sz) ? '0 : z_inc[vbad_pkg::AXIS_W-1:0];
        end else begin
          y_nxt = y_inc[vbad_pkg::AXIS_W-1:0];
        end
      end else begin
        x_nxt = x_inc[vbad_pkg::AXIS_W-1:0];
      end
    end
  end

  // cube counts follow the configuration every cycle
  always_comb begin
    pnx     = vbad_pkg::AXPROD_W'(sx) * vbad_pkg::AXPROD_W'(rf);
    pny     = vbad_pkg::AXPROD_W'(sy) * vbad_pkg::AXPROD_W'(rf);
    pnz     = vbad_pkg::AXPROD_W'(sz) * vbad_pkg::AXPROD_W'(rf);
    ncx_nxt = pnx[vbad_pkg::RCP_SH +: vbad_pkg::SIZE_W];
    ncy_nxt = pny[vbad_pkg::RCP_SH +: vbad_pkg::SIZE_W];
    ncz_nxt = pnz[vbad_pkg::RCP_SH +: vbad_pkg::SIZE_W];
  end

  always_ff @(posedge clk) begin
    ncx_r <= ncx_nxt;
    ncy_r <= ncy_nxt;
    ncz_r <= ncz_nxt;
  end

  // cursor quotients by factor
  always_comb begin
    px = vbad_pkg::AXPROD_W'(x1_r) * vbad_pkg::AXPROD_W'(rf);
    py = vbad_pkg::AXPROD_W'(y1_r) * vbad_pkg::AXPROD_W'(rf);
    pz = vbad_pkg::AXPROD_W'(z1_r) * vbad_pkg::AXPROD_W'(rf);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r     <= '0;
      y_r     <= '0;
      z_r     <= '0;
      st1_v_r <= 1'b0;
      st2_v_r <= 1'b0;
    end else begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      st1_v_r <= accept;
      st2_v_r <= st1_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      x1_r <= x_r;
      y1_r <= y_r;
      z1_r <= z_r;
      s1_r <= in_ch.sample;
    end
    if (st1_v_r) begin
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      z2_r  <= z1_r;
      s2_r  <= s1_r;
      qx2_r <= px[vbad_pkg::RCP_SH +: vbad_pkg::AXIS_W];
      qy2_r <= py[vbad_pkg::RCP_SH +: vbad_pkg::AXIS_W];
      qz2_r <= pz[vbad_pkg::RCP_SH +: vbad_pkg::AXIS_W];
    end
  end

  // remainders, cube flags and plane index
  always_comb begin
    mx    = vbad_pkg::SIZE_W'(qx2_r) * vbad_pkg::SIZE_W'(f);
    my    = vbad_pkg::SIZE_W'(qy2_r) * vbad_pkg::SIZE_W'(f);
    mz    = vbad_pkg::SIZE_W'(qz2_r) * vbad_pkg::SIZE_W'(f);
    dx    = {1'b0, x2_r} - mx;
    dy    = {1'b0, y2_r} - my;
    dz    = {1'b0, z2_r} - mz;
    rx    = dx[vbad_pkg::REM_W-1:0];
    ry    = dy[vbad_pkg::REM_W-1:0];
    rz    = dz[vbad_pkg::REM_W-1:0];
    inbox = ({1'b0, qx2_r} < ncx_r) && ({1'b0, qy2_r} < ncy_r)
         && ({1'b0, qz2_r} < ncz_r);
    first = (rx == '0) && (ry == '0) && (rz == '0);
    lastv = (rx == rlast) && (ry == rlast) && (rz == rlast);
    lastc = ({1'b0, qx2_r} == ncx_r - 1'b1) && ({1'b0, qy2_r} == ncy_r - 1'b1)
         && ({1'b0, qz2_r} == ncz_r - 1'b1);
    idx   = vbad_pkg::IDX_W'(qy2_r) * vbad_pkg::IDX_W'(ncx_r)
          + vbad_pkg::IDX_W'(qx2_r);
  end

  // items outside every whole cube are dropped here
  always_comb begin
    push.valid       = st2_v_r && inbox;
    push.ent.sample  = s2_r;
    push.ent.addr    = idx[vbad_pkg::ADDR_W-1:0];
    push.ent.addr_ok = (idx < vbad_pkg::IDX_W'(vbad_pkg::PLANE_ENTRIES));
    push.ent.first   = first;
    push.ent.emit    = lastv;
    push.ent.last    = lastc;
    push.ent.pass    = (f == vbad_pkg::FACTOR_W'(1));
  end

endmodule

// File: src/vbad_back.sv
module vbad_back (
  input  logic              clk,
  input  logic              rst_n,
  input  vbad_pkg::cfg_t    cfg,
  input  vbad_pkg::q_ent_t  q_ent,
  input  vbad_pkg::q_stat_t q_stat,
  output logic              pop,
  vbad_out_if.source        out_ch
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SUM  = 4'b0010,
    B_MUL  = 4'b0100,
    B_OUT  = 4'b1000
  } bk_state_t;

  bk_state_t state_r, state_nxt;

  logic [vbad_pkg::SUM_W-1:0] plane_mem [vbad_pkg::PLANE_ENTRIES];

  vbad_pkg::q_ent_t              ent_r;
  logic [vbad_pkg::SUM_W-1:0]    rd_r;
  logic [vbad_pkg::SUM_W-1:0]    sum_r;
  logic                          neg_r;
  logic [vbad_pkg::PROD_W-1:0]   prod_r;

  logic                                 out_valid_r, out_valid_nxt;
  logic signed [vbad_pkg::SAMPLE_W-1:0] out_avg_r;
  logic                                 out_last_r;

  logic [vbad_pkg::FACTOR_W-1:0]        f;
  logic [vbad_pkg::SUM_W-1:0]           prev, sum, mag;
  logic [vbad_pkg::PROD_W-1:0]          prod;
  logic [vbad_pkg::QUO_W-1:0]           quo;
  logic signed [vbad_pkg::QUO_W:0]      sq;
  logic signed [vbad_pkg::SAMPLE_W-1:0] sat, avg_pre, avg_fin;
  logic                                 load;

  assign f   = vbad_pkg::clamp_factor(cfg.factor);
  assign pop = (state_r == B_IDLE) && !q_stat.empty;

  // partial sum update, wraps at the store width
  always_comb begin
    prev = (ent_r.first || !ent_r.addr_ok) ? '0 : rd_r;
    sum  = prev + {{(vbad_pkg::SUM_W-vbad_pkg::SAMPLE_W){ent_r.sample[vbad_pkg::SAMPLE_W-1]}},
                   ent_r.sample};
  end

  // magnitude times reciprocal of the cube volume
  always_comb begin
    mag  = sum_r[vbad_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
    prod = vbad_pkg::PROD_W'(mag) * vbad_pkg::PROD_W'(vbad_pkg::recip_cube(f));
  end

  // signed average, saturation and binarize
  always_comb begin
    quo = prod_r[vbad_pkg::RCP3_SH +: vbad_pkg::QUO_W];
    sq  = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (sq > (vbad_pkg::QUO_W+1)'(32767)) sat = 16'sh7fff;
    else if (sq < -(vbad_pkg::QUO_W+1)'(32768)) sat = 16'sh8000;
    else sat = sq[vbad_pkg::SAMPLE_W-1:0];
    avg_pre = ent_r.pass ? ent_r.sample : sat;
    if (cfg.binarize) begin
      avg_fin = (avg_pre > 16'sd0) ? $signed(vbad_pkg::SAMPLE_W'(cfg.fill_value)) : '0;
    end else begin
      avg_fin = avg_pre;
    end
  end

  assign load = (state_r == B_OUT) && (!out_valid_r || out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) state_nxt = q_ent.pass ? B_OUT : B_SUM;
      end
      B_SUM: begin
        state_nxt = ent_r.emit ? B_MUL : B_IDLE;
      end
      B_MUL: begin
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (load) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (pop) ent_r <= q_ent;
    if (state_r == B_SUM) sum_r <= sum;
    if (state_r == B_MUL) begin
      neg_r  <= sum_r[vbad_pkg::SUM_W-1];
      prod_r <= prod;
    end
    if (load) begin
      out_avg_r  <= avg_fin;
      out_last_r <= ent_r.last;
    end
  end

  // plane store of partial sums
  always_ff @(posedge clk) begin
    if ((state_r == B_SUM) && ent_r.addr_ok) plane_mem[ent_r.addr] <= sum;
    if (pop) rd_r <= plane_mem[q_ent.addr];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.average        = out_avg_r;
  assign out_ch.last_of_volume = out_last_r;

endmodule

// File: test/tb_volume_block_average_downsampler.sv
module tb_volume_block_average_downsampler;
  import vbad_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       last_vol;
  } cube_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  vbad_in_if in_ch();
  vbad_out_if out_ch();

  volume_block_average_downsampler DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // voxels waiting to be offered, cube results waiting to come out
  logic signed [SAMPLE_W-1:0] voxel_q[$];
  cube_result_t cube_avg_q[$];

  // register copies
  logic [SIZE_W-1:0] geo_x, geo_y, geo_z;
  logic [FACTOR_W-1:0] geo_factor;
  logic bin_mode;
  logic [FILL_W-1:0] fill_level;

  // raster position and partial sums of the current slab of cubes
  int vox_x, vox_y, vox_z;
  bit signed [SUM_W-1:0] slab_sums [PLANE_ENTRIES];

  int voxels_sent = 0;
  int cubes_seen = 0;
  int fail_count = 0;
  int idle_mode = 0;
  logic hold_armed = 1'b0;
  logic hold_done;
  int hold_left;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int axis_len(input logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_AXIS) return MAX_AXIS;
    return int'(v);
  endfunction

  // fold one accepted voxel into the slab sums, queue the cube result it completes
  task automatic fold_voxel(input logic signed [SAMPLE_W-1:0] s);
    int sx, sy, sz, f, ncx, ncy, ncz, cx, cy, cz, idx, avg;
    bit emit, at_end, first_vox;
    logic signed [SUM_W-1:0] acc;
    cube_result_t res;
    sx = axis_len(geo_x);
    sy = axis_len(geo_y);
    sz = axis_len(geo_z);
    f = (geo_factor == '0) ? 1 : (geo_factor > MAX_FACTOR) ? MAX_FACTOR : int'(geo_factor);
    ncx = sx / f;
    ncy = sy / f;
    ncz = sz / f;
    emit = 1'b0;
    at_end = 1'b0;
    avg = 0;
    if (vox_x < ncx * f && vox_y < ncy * f && vox_z < ncz * f) begin
      cx = vox_x / f;
      cy = vox_y / f;
      cz = vox_z / f;
      at_end = (cx == ncx - 1) && (cy == ncy - 1) && (cz == ncz - 1);
      if (f == 1) begin
        avg = int'(s);
        emit = 1'b1;
      end else begin
        idx = cy * ncx + cx;
        first_vox = (vox_x % f == 0) && (vox_y % f == 0) && (vox_z % f == 0);
        if (first_vox) acc = SUM_W'(s);
        else acc = slab_sums[idx] + s;
        slab_sums[idx] = acc;
        if ((vox_x % f == f - 1) && (vox_y % f == f - 1) && (vox_z % f == f - 1)) begin
          // signed int division truncates toward zero
          avg = int'(acc) / (f * f * f);
          if (avg > 32767) avg = 32767;
          else if (avg < -32768) avg = -32768;
          emit = 1'b1;
        end
      end
    end
    // raster step, x fastest
    if (vox_x + 1 >= sx) begin
      vox_x = 0;
      if (vox_y + 1 >= sy) begin
        vox_y = 0;
        vox_z = (vox_z + 1 >= sz) ? 0 : vox_z + 1;
      end else begin
        vox_y = vox_y + 1;
      end
    end else begin
      vox_x = vox_x + 1;
    end
    if (emit) begin
      if (bin_mode) avg = (avg > 0) ? int'(fill_level) : 0;
      res.average = avg[SAMPLE_W-1:0];
      res.last_vol = at_end;
      cube_avg_q.push_back(res);
    end
  endtask

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // sender: hold the item until taken, then maybe idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) fold_voxel(in_ch.sample);
      if (!in_ch.valid || in_ch.ready) begin
        if (voxel_q.size() > 0 &&
            $urandom_range(0, 99) >= (idle_mode == 0 ? 24 : idle_mode == 1 ? 59 : 0)) begin
          in_ch.valid <= 1'b1;
          in_ch.sample <= voxel_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started by the first item taken once armed
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_armed && !hold_done && in_ch.valid && in_ch.ready) begin
      hold_left <= 100;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: compare each result with the oldest expected one
  always @(posedge clk) begin
    cube_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        cubes_seen++;
        if (cube_avg_q.size() == 0) begin
          flag_error($sformatf("result %0d: average %0d last %0b with nothing expected",
                               cubes_seen, out_ch.average, out_ch.last_of_volume));
        end else begin
          want = cube_avg_q.pop_front();
          if (out_ch.average !== want.average || out_ch.last_of_volume !== want.last_vol)
            flag_error($sformatf("result %0d: average %0d expected %0d, last %0b expected %0b",
                                 cubes_seen, out_ch.average, want.average,
                                 out_ch.last_of_volume, want.last_vol));
        end
      end
      out_ch.ready <= (hold_left == 0) &&
        ($urandom_range(0, 99) >= (idle_mode == 0 ? 59 : idle_mode == 1 ? 24 : 0));
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_SIZE_X:     geo_x = value[SIZE_W-1:0];
      CFG_SIZE_Y:     geo_y = value[SIZE_W-1:0];
      CFG_SIZE_Z:     geo_z = value[SIZE_W-1:0];
      CFG_FACTOR:     geo_factor = value[FACTOR_W-1:0];
      CFG_BINARIZE:   bin_mode = value[0];
      CFG_FILL_VALUE: fill_level = value[FILL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_volume(input int sx, input int sy, input int sz, input int f,
                            input int bin, input int fill);
    write_reg(CFG_SIZE_X, sx);
    write_reg(CFG_SIZE_Y, sy);
    write_reg(CFG_SIZE_Z, sz);
    write_reg(CFG_FACTOR, f);
    write_reg(CFG_BINARIZE, bin);
    write_reg(CFG_FILL_VALUE, fill);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic offer_voxel(input logic signed [SAMPLE_W-1:0] s);
    voxel_q.push_back(s);
    voxels_sent++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_voxel();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: return SAMPLE_W'($urandom);
      3:       return 16'sh7fff;
      4:       return 16'sh8000;
      5:       return SAMPLE_W'(int'($urandom_range(0, 2)) - 1);
      default: return SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // all offered items taken and every result back, then let the pipe settle
  task automatic wait_drained();
    while (voxel_q.size() != 0 || in_ch.valid || cube_avg_q.size() != 0) @(negedge clk);
    repeat (64) @(posedge clk);
  endtask

  // one whole volume of random voxels
  task automatic run_volume(input int sx, input int sy, input int sz, input int f,
                            input int bin, input int fill);
    int n;
    set_volume(sx, sy, sz, f, bin, fill);
    n = axis_len(sx) * axis_len(sy) * axis_len(sz);
    repeat (n) offer_voxel(rand_voxel());
    wait_drained();
  endtask

  initial begin
    int p, r, fr, lo, hi, bx, by, bz;
    logic signed [SAMPLE_W-1:0] v;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    geo_x = SIZE_W'(512);
    geo_y = SIZE_W'(512);
    geo_z = SIZE_W'(512);
    geo_factor = FACTOR_W'(2);
    bin_mode = 1'b0;
    fill_level = FILL_W'(255);
    vox_x = 0;
    vox_y = 0;
    vox_z = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // oversized row at factor zero: pass-through of the sample extremes
    set_volume(1023, 1, 1, 0, 0, 255);
    offer_voxel(16'sh8000);
    offer_voxel(16'sh7fff);
    offer_voxel(-16'sd1);
    offer_voxel(16'sd0);
    wait_drained();

    // shrink to one voxel mid-row: the stray cursor wraps, then binarized voxels
    set_volume(0, 0, 0, 1, 1, 'hA5);
    offer_voxel(rand_voxel());
    offer_voxel(16'sh7fff);
    offer_voxel(16'sh8000);
    offer_voxel(16'sd1);
    offer_voxel(16'sd0);
    wait_drained();

    // factor above the limit, larger than every axis: nothing comes out
    set_volume(0, 0, 0, 15, 0, 255);
    offer_voxel(rand_voxel());
    offer_voxel(rand_voxel());
    wait_drained();

    // two cubes: most negative average, then a negative sum truncated toward zero
    set_volume(2, 2, 2, 2, 0, 255);
    repeat (8) offer_voxel(16'sh8000);
    offer_voxel(-16'sd3);
    repeat (5) offer_voxel(-16'sd2);
    repeat (2) offer_voxel(-16'sd1);
    wait_drained();

    p = 0;
    while (p < 10 || voxels_sent < 700) begin
      idle_mode = (p < 3) ? 0 : (p < 6) ? 1 : 2;
      if (p == 1) begin
        // nine voxels into a 3-cube, then factor two mid-volume: the average saturates
        v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        set_volume(3, 3, 3, 3, 0, 255);
        repeat (9) offer_voxel(v);
        wait_drained();
        set_volume(2, 2, 2, 2, $urandom_range(0, 1), $urandom_range(0, 255));
        repeat (4) offer_voxel(v);
        wait_drained();
      end else if (p == 8) begin
        run_volume(8, 8, 8, 8, $urandom_range(0, 1), $urandom_range(0, 255));
      end else if (p == 7) begin
        // receiver stalls long while voxels keep coming
        hold_armed = 1'b1;
        run_volume(8, 4, 2, 1, 0, $urandom_range(0, 255));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) fr = 0;
        else if (r < 20) fr = 1;
        else if (r < 55) fr = 2;
        else if (r < 75) fr = 3;
        else if (r < 88) fr = 4;
        else if (r < 93) fr = 5;
        else fr = $urandom_range(9, 15);
        if (fr <= 1) begin
          bx = $urandom_range(1, 6);
          by = $urandom_range(0, 3);
          bz = $urandom_range(1, 2);
        end else begin
          case (fr)
            2: begin lo = 1; hi = 4; end
            3: begin lo = 2; hi = 4; end
            4: begin lo = 3; hi = 4; end
            5: begin lo = 5; hi = 5; end
            default: begin lo = 1; hi = 3; end
          endcase
          bx = $urandom_range(lo, hi);
          by = $urandom_range(lo, hi);
          bz = $urandom_range(lo, hi);
        end
        run_volume(bx, by, bz, fr, ($urandom_range(0, 99) < 30) ? 1 : 0,
                   $urandom_range(0, 255));
      end
      p++;
    end

    if (fail_count == 0 && cube_avg_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #(20 * 400000);
    $display("simulation failed");
    $finish;
  end

endmodule
